@@ design/svjp_pkg.sv @@
// Shared constants, codes and a helper function of the servo joint slew-to-pulse block.
package svjp_pkg;

  localparam int unsigned LEGS_DEFAULT    = 6;
  localparam int unsigned JOINTS          = 3;
  localparam int unsigned INVERT_FROM_LEG = 3;

  localparam int unsigned ANGLE_W = 15;
  localparam int unsigned TRIM_W  = 13;
  localparam int unsigned RATE_W  = 10;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned LEG_W   = 3;
  localparam int unsigned JOINT_W = 2;
  localparam int unsigned WIDTH_W = 9;
  localparam int unsigned STEP_W  = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_W  = 28;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(180);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RATE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COXA_TRIM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEMUR_TRIM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIBIA_TRIM  = 2'd3;

  // Joint codes.
  localparam logic [JOINT_W-1:0] JOINT_COXA  = 2'd0;
  localparam logic [JOINT_W-1:0] JOINT_FEMUR = 2'd1;
  localparam logic [JOINT_W-1:0] JOINT_TIBIA = 2'd2;

  // Slew step is floor(rate * dt / 15625); exact through this reciprocal and a
  // right shift by STEP_SHIFT for every 26-bit rate*dt product.
  localparam logic [MUL_W-1:0] STEP_RECIP = MUL_W'(70368745);
  localparam int unsigned      STEP_SHIFT = 40;

  // Pulse in us*6400 units.
  localparam logic signed [MUL_W-1:0] PULSE_CENTER   = MUL_W'(9600000);
  localparam logic signed [MUL_W-1:0] PULSE_PER_UNIT = MUL_W'(1111);
  localparam int unsigned             PULSE_W        = 24;
  localparam logic [PULSE_W-1:0]      PULSE_MIN      = PULSE_W'(3123200);
  localparam logic [PULSE_W-1:0]      PULSE_MAX      = PULSE_W'(15315200);

  // floor(P / 31250) = floor((P >> 1) / 15625), exact for 23-bit operands.
  localparam logic [MUL_W-1:0] WIDTH_RECIP = MUL_W'(8796094);
  localparam int unsigned      WIDTH_SHIFT = 37;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};

  // Negation that saturates the most negative angle to the most positive one.
  function automatic logic signed [ANGLE_W-1:0] neg_sat(input logic signed [ANGLE_W-1:0] a);
    logic signed [ANGLE_W-1:0] r;
    if (a == ANGLE_MIN) begin
      r = ANGLE_MAX;
    end else begin
      r = -a;
    end
    return r;
  endfunction

endpackage

@@ design/servo_joint_slew_to_pulse_core.sv @@
// Top level of the servo joint driver: target store, slew limiter and pulse width mapping.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one request per item.
// A store request (mode 0) writes the three joint targets of one leg in the cycle it
// is accepted; a leg beyond the configured count is dropped. A tick request (mode 1)
// advances every joint toward its target and returns LEGS*3 results on the output
// channel (out_valid_o / out_stall_i), leg by leg, coxa, femur, tibia, with last_o
// set on the final one.
// Timing: a store does not make the block busy. A tick first forms the slew step
// (ST_RATE, ST_STEP, ST_SAVE) and then walks each joint through ST_SLEW, ST_PULSE,
// ST_CLAMP, ST_DIV and ST_EMIT. All multiplications run through one 28x28 multiplier
// that the sequencer time-shares: rate*dt, the step reciprocal, the pulse slope and the
// width reciprocal. in_stall_o is high for the whole tick.
// The result sits in an output register; a stall on out_stall_i holds it and
// freezes the sequencer at the next result until the register frees up.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always accepted.
// Reset clears all targets and current angles to zero, the rate to 180 deg/s and
// the trims to zero.
module servo_joint_slew_to_pulse_core
  import svjp_pkg::*;
#(
  parameter int unsigned LEGS = LEGS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  // Input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [LEG_W-1:0]           leg_i,
  input  logic signed [ANGLE_W-1:0]  alpha_i,
  input  logic signed [ANGLE_W-1:0]  beta_i,
  input  logic signed [ANGLE_W-1:0]  gamma_i,
  input  logic [DT_W-1:0]            tick_time_us_i,
  // Output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [LEG_W-1:0]           out_leg_o,
  output logic [JOINT_W-1:0]         joint_o,
  output logic [WIDTH_W-1:0]         width_ticks_o,
  output logic signed [ANGLE_W-1:0]  applied_angle_o,
  output logic                       last_o
);

  localparam int unsigned DEPTH = LEGS * JOINTS;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RATE  = 9'b000000010,
    ST_STEP  = 9'b000000100,
    ST_SAVE  = 9'b000001000,
    ST_SLEW  = 9'b000010000,
    ST_PULSE = 9'b000100000,
    ST_CLAMP = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [RATE_W-1:0]         rate_q;
  logic signed [TRIM_W-1:0]  trim_q [JOINTS];
  logic signed [ANGLE_W-1:0] tgt_q  [DEPTH];
  logic signed [ANGLE_W-1:0] cur_q  [DEPTH];

  logic [DT_W-1:0]           dt_q;
  logic [STEP_W-1:0]         step_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ANGLE_W-1:0] ang_q;
  logic [PULSE_W-1:0]        pclamp_q;
  logic [IDX_W-1:0]          idx_q;
  logic [LEG_W-1:0]          leg_q;
  logic [JOINT_W-1:0]        jnt_q;

  logic                      out_valid_q;
  logic [LEG_W-1:0]          out_leg_q;
  logic [JOINT_W-1:0]        joint_q;
  logic [WIDTH_W-1:0]        width_q;
  logic signed [ANGLE_W-1:0] applied_q;
  logic                      last_q;

  logic in_accept;
  logic store_we;
  logic tick_go;
  logic slot_free;
  logic emit;
  logic final_joint;
  logic [IDX_W-1:0] base_idx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign store_we    = in_accept && !mode_i && (32'(leg_i) < LEGS);
  assign tick_go     = in_accept && mode_i;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign emit        = (state_q == ST_EMIT) && slot_free;
  assign final_joint = (leg_q == LEG_W'(LEGS - 1)) && (jnt_q == JOINT_TIBIA);
  assign base_idx    = IDX_W'({2'b00, leg_i} * 5'd3);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
      for (int i = 0; i < JOINTS; i++) begin
        trim_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RATE:       rate_q    <= cfg_data_i[RATE_W-1:0];
        CFG_COXA_TRIM:  trim_q[0] <= cfg_data_i;
        CFG_FEMUR_TRIM: trim_q[1] <= cfg_data_i;
        CFG_TIBIA_TRIM: trim_q[2] <= cfg_data_i;
        default:        rate_q    <= rate_q;
      endcase
    end
  end

  // Target store; the tibia target is kept negated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        tgt_q[i] <= '0;
      end
    end else if (store_we) begin
      tgt_q[base_idx]                <= alpha_i;
      tgt_q[base_idx + IDX_W'(1)]    <= beta_i;
      tgt_q[base_idx + IDX_W'(2)]    <= neg_sat(gamma_i);
    end
  end

  // Slew limiter for the joint under the sequencer.
  logic signed [ANGLE_W:0] diff;
  logic signed [ANGLE_W:0] step_s;
  logic signed [ANGLE_W:0] diff_lim;
  logic signed [ANGLE_W:0] cur_new;

  always_comb begin
    diff   = {tgt_q[idx_q][ANGLE_W-1], tgt_q[idx_q]} - {cur_q[idx_q][ANGLE_W-1], cur_q[idx_q]};
    step_s = signed'({{(ANGLE_W + 1 - STEP_W){1'b0}}, step_q});
    if (diff > step_s) begin
      diff_lim = step_s;
    end else if (diff < -step_s) begin
      diff_lim = -step_s;
    end else begin
      diff_lim = diff;
    end
    cur_new = {cur_q[idx_q][ANGLE_W-1], cur_q[idx_q]} + diff_lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        cur_q[i] <= '0;
      end
    end else if (state_q == ST_SLEW) begin
      cur_q[idx_q] <= cur_new[ANGLE_W-1:0];
    end
  end

  // Pulse operand: angle, inverted on the far side of the body, plus trim.
  logic signed [ANGLE_W:0]   ang_ext;
  logic signed [ANGLE_W:0]   ang_dir;
  logic signed [TRIM_W-1:0]  trim_sel;
  logic signed [ANGLE_W+1:0] pulse_sum;

  always_comb begin
    case (jnt_q)
      JOINT_COXA:  trim_sel = trim_q[0];
      JOINT_FEMUR: trim_sel = trim_q[1];
      default:     trim_sel = trim_q[2];
    endcase
    ang_ext   = {ang_q[ANGLE_W-1], ang_q};
    ang_dir   = (leg_q >= LEG_W'(INVERT_FROM_LEG)) ? -ang_ext : ang_ext;
    pulse_sum = {ang_dir[ANGLE_W], ang_dir}
              + {{(ANGLE_W + 2 - TRIM_W){trim_sel[TRIM_W-1]}}, trim_sel};
  end

  // Shared multiplier.
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_RATE: begin
        mul_a = signed'(MUL_W'(rate_q));
        mul_b = signed'(MUL_W'(dt_q));
      end
      ST_STEP: begin
        mul_a = signed'(MUL_W'(prod_q[RATE_W+DT_W-1:0]));
        mul_b = signed'(STEP_RECIP);
      end
      ST_PULSE: begin
        mul_a = MUL_W'(pulse_sum);
        mul_b = PULSE_PER_UNIT;
      end
      ST_DIV: begin
        mul_a = signed'(MUL_W'(pclamp_q[PULSE_W-1:1]));
        mul_b = signed'(WIDTH_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [MUL_W-1:0] pulse_raw;
  assign pulse_raw = PULSE_CENTER + prod_q[MUL_W-1:0];

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (tick_go) state_d = ST_RATE;
      ST_RATE:  state_d = ST_STEP;
      ST_STEP:  state_d = ST_SAVE;
      ST_SAVE:  state_d = ST_SLEW;
      ST_SLEW:  state_d = ST_PULSE;
      ST_PULSE: state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_DIV;
      ST_DIV:   state_d = ST_EMIT;
      ST_EMIT:  if (emit) state_d = final_joint ? ST_IDLE : ST_SLEW;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      leg_q   <= '0;
      jnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SAVE) begin
        idx_q <= '0;
        leg_q <= '0;
        jnt_q <= JOINT_COXA;
      end else if (emit && !final_joint) begin
        idx_q <= idx_q + IDX_W'(1);
        if (jnt_q == JOINT_TIBIA) begin
          jnt_q <= JOINT_COXA;
          leg_q <= leg_q + LEG_W'(1);
        end else begin
          jnt_q <= jnt_q + JOINT_W'(1);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      dt_q <= tick_time_us_i;
    end
    if (state_q == ST_RATE || state_q == ST_STEP || state_q == ST_PULSE ||
        state_q == ST_DIV) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == ST_SAVE) begin
      step_q <= prod_q[STEP_SHIFT+STEP_W-1:STEP_SHIFT];
    end
    if (state_q == ST_SLEW) begin
      ang_q <= cur_new[ANGLE_W-1:0];
    end
    if (state_q == ST_CLAMP) begin
      if (pulse_raw < signed'(MUL_W'(PULSE_MIN))) begin
        pclamp_q <= PULSE_MIN;
      end else if (pulse_raw > signed'(MUL_W'(PULSE_MAX))) begin
        pclamp_q <= PULSE_MAX;
      end else begin
        pclamp_q <= pulse_raw[PULSE_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_leg_q <= leg_q;
      joint_q   <= jnt_q;
      width_q   <= prod_q[WIDTH_SHIFT+WIDTH_W-1:WIDTH_SHIFT];
      applied_q <= (jnt_q == JOINT_TIBIA) ? neg_sat(ang_q) : ang_q;
      last_q    <= final_joint;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_leg_o       = out_leg_q;
  assign joint_o         = joint_q;
  assign width_ticks_o   = width_q;
  assign applied_angle_o = applied_q;
  assign last_o          = last_q;

endmodule

@@ design/svjp_checker.sv @@
// Port-level assertions for the servo joint driver, bound to its top level.
module svjp_checker
  import svjp_pkg::*;
#(
  parameter int unsigned LEGS = LEGS_DEFAULT
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       mode_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [LEG_W-1:0]           out_leg_o,
  input logic [JOINT_W-1:0]         joint_o,
  input logic [WIDTH_W-1:0]         width_ticks_o,
  input logic signed [ANGLE_W-1:0]  applied_angle_o,
  input logic                       last_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(width_ticks_o) &&
    $stable(applied_angle_o) && $stable(out_leg_o) && $stable(joint_o) && $stable(last_o))
    else $error("stalled result changed");

  // The clamped pulse always maps into 99..490 ticks.
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> width_ticks_o >= WIDTH_W'(99) && width_ticks_o <= WIDTH_W'(490))
    else $error("pulse width out of range");

  a_joint_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> joint_o == JOINT_COXA || joint_o == JOINT_FEMUR || joint_o == JOINT_TIBIA)
    else $error("bad joint code");

  // Only the tibia of the final leg closes a tick.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> joint_o == JOINT_TIBIA && out_leg_o == LEG_W'(LEGS - 1))
    else $error("last flag on wrong joint");

  // A store request does not leave the block busy.
  a_store_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !mode_i |=> !in_stall_o)
    else $error("store request left the block busy");

endmodule

bind servo_joint_slew_to_pulse_core svjp_checker #(.LEGS(LEGS)) u_svjp_checker (.*);

@@ test/testbench.sv @@
// Testbench for the servo joint slew-to-pulse core: a directed table and random requests checked against a joint model.
`timescale 1ns / 1ps

module testbench;
  import svjp_pkg::*;

  localparam int NUM_LEGS      = LEGS_DEFAULT;
  localparam int SLOT_COUNT    = NUM_LEGS * JOINTS;
  localparam int RATE_AT_RESET = 180;
  localparam int IDLE_SETTLE   = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int END_DRAIN     = 200;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int REPORT_MAX    = 10;

  // Pulse width arithmetic in microseconds times 6400.
  localparam longint PW_CENTER   = 9600000;
  localparam longint PW_SLOPE    = 1111;
  localparam longint PW_FLOOR    = 3123200;
  localparam longint PW_CEIL     = 15315200;
  localparam longint PW_PER_TICK = 31250;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ROW_STORE,
    ROW_TICK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [LEG_W-1:0]       leg;
    logic [ANGLE_W-1:0]     alpha;
    logic [ANGLE_W-1:0]     beta;
    logic [ANGLE_W-1:0]     gamma;
    logic [DT_W-1:0]        dt;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   typed;
    logic [4:0]             typed_slot;
    logic [WIDTH_W-1:0]     typed_width;
    logic [ANGLE_W-1:0]     typed_angle;
  } stim_row_t;

  typedef struct packed {
    logic [LEG_W-1:0]          leg;
    logic [JOINT_W-1:0]        joint;
    logic [WIDTH_W-1:0]        width;
    logic signed [ANGLE_W-1:0] angle;
    logic                      last;
  } joint_result_t;

  logic                      clk;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      mode_i;
  logic [LEG_W-1:0]          leg_i;
  logic signed [ANGLE_W-1:0] alpha_i;
  logic signed [ANGLE_W-1:0] beta_i;
  logic signed [ANGLE_W-1:0] gamma_i;
  logic [DT_W-1:0]           tick_time_us_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [LEG_W-1:0]          out_leg_o;
  logic [JOINT_W-1:0]        joint_o;
  logic [WIDTH_W-1:0]        width_ticks_o;
  logic signed [ANGLE_W-1:0] applied_angle_o;
  logic                      last_o;

  // Joint model state.
  logic signed [ANGLE_W-1:0] target_q [SLOT_COUNT];
  logic signed [ANGLE_W-1:0] current_q [SLOT_COUNT];
  logic [RATE_W-1:0]         rate_q;
  logic signed [TRIM_W-1:0]  trim_q [JOINTS];
  joint_result_t             tick_results [SLOT_COUNT];
  joint_result_t             pending_joints [$];
  stim_row_t                 dir_rows [$];

  int errors;
  bit hold_req;
  bit hold_long;
  bit calm;

  servo_joint_slew_to_pulse_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .leg_i           (leg_i),
    .alpha_i         (alpha_i),
    .beta_i          (beta_i),
    .gamma_i         (gamma_i),
    .tick_time_us_i  (tick_time_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_leg_o       (out_leg_o),
    .joint_o         (joint_o),
    .width_ticks_o   (width_ticks_o),
    .applied_angle_o (applied_angle_o),
    .last_o          (last_o)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Negation that keeps the most negative angle in range.
  function automatic logic signed [ANGLE_W-1:0] flip_angle(input logic signed [ANGLE_W-1:0] a);
    logic signed [ANGLE_W-1:0] r;
    if (int'(a) == -16384) begin
      r = 15'sd16383;
    end else begin
      r = -a;
    end
    return r;
  endfunction

  // Slews every joint by one tick and fills tick_results in output order.
  function automatic void advance_joints(input logic [DT_W-1:0] dt);
    longint step;
    longint diff;
    longint p;
    int     idx;
    int     ang;
    int     shown;
    step = (longint'(rate_q) * longint'(dt) * 64) / 1000000;
    for (idx = 0; idx < SLOT_COUNT; idx++) begin
      diff = longint'(target_q[idx]) - longint'(current_q[idx]);
      if (diff > step) diff = step;
      if (diff < -step) diff = -step;
      current_q[idx] = ANGLE_W'(longint'(current_q[idx]) + diff);
      ang = int'(current_q[idx]);
      shown = (idx % JOINTS == 2) ? int'(flip_angle(current_q[idx])) : ang;
      // Legs on the far side are mounted mirrored.
      if (idx / JOINTS >= INVERT_FROM_LEG) ang = -ang;
      p = PW_CENTER + PW_SLOPE * longint'(ang + int'(trim_q[idx % JOINTS]));
      if (p < PW_FLOOR) p = PW_FLOOR;
      if (p > PW_CEIL) p = PW_CEIL;
      tick_results[idx].leg   = LEG_W'(idx / JOINTS);
      tick_results[idx].joint = JOINT_W'(idx % JOINTS);
      tick_results[idx].width = WIDTH_W'(p / PW_PER_TICK);
      tick_results[idx].angle = ANGLE_W'(shown);
      tick_results[idx].last  = (idx == SLOT_COUNT - 1);
    end
  endfunction

  function automatic stim_row_t item_row(input row_kind_e kind, input int leg, input int a,
                                         input int b, input int g, input int dt);
    stim_row_t r;
    r = '0;
    r.kind  = kind;
    r.leg   = LEG_W'(leg);
    r.alpha = ANGLE_W'(a);
    r.beta  = ANGLE_W'(b);
    r.gamma = ANGLE_W'(g);
    r.dt    = DT_W'(dt);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] index, input int data);
    stim_row_t r;
    r = '0;
    r.kind      = ROW_CFG;
    r.cfg_index = index;
    r.cfg_data  = CFG_DATA_W'(data);
    return r;
  endfunction

  function automatic stim_row_t with_check(input stim_row_t r, input int slot, input int w,
                                           input int ang);
    stim_row_t c;
    c = r;
    c.typed       = 1'b1;
    c.typed_slot  = 5'(slot);
    c.typed_width = WIDTH_W'(w);
    c.typed_angle = ANGLE_W'(ang);
    return c;
  endfunction

  function automatic int random_angle();
    int v;
    if ($urandom_range(0, 6) == 0) begin
      v = int'($urandom_range(0, 32767)) - 16384;
    end else begin
      v = int'($urandom_range(0, 23040)) - 11520;
    end
    return v;
  endfunction

  function automatic stim_row_t random_request();
    int        d;
    row_kind_e kind;
    int        leg;
    int        dt;
    d = $urandom_range(0, 9);
    kind = ($urandom_range(0, 9) < 6) ? ROW_STORE : ROW_TICK;
    leg = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
    if (d == 0) begin
      dt = 0;
    end else if (d == 1) begin
      dt = 65535;
    end else if (d == 2) begin
      dt = $urandom_range(0, 65535);
    end else begin
      dt = $urandom_range(1000, 20000);
    end
    return item_row(kind, leg, random_angle(), random_angle(), random_angle(), dt);
  endfunction

  // Drops valid and waits until every tick result has been collected.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_joints.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 9);
    if (calm || r < 5) begin
      n = 0;
    end else if (r < 9) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(15, 50);
    end
    if (n > 0) begin
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Called and returns at a falling edge.
  task automatic apply_row(input stim_row_t r);
    int i;
    if (r.kind == ROW_CFG) begin
      wait_idle();
      cfg_valid_i = 1'b1;
      cfg_index_i = r.cfg_index;
      cfg_data_i  = r.cfg_data;
      @(posedge clk);
      while (!cfg_ready_o) @(posedge clk);
      case (r.cfg_index)
        CFG_RATE:       rate_q    = r.cfg_data[RATE_W-1:0];
        CFG_COXA_TRIM:  trim_q[0] = r.cfg_data;
        CFG_FEMUR_TRIM: trim_q[1] = r.cfg_data;
        CFG_TIBIA_TRIM: trim_q[2] = r.cfg_data;
        default: ;
      endcase
      @(negedge clk);
      cfg_valid_i = 1'b0;
    end else begin
      in_valid_i     = 1'b1;
      mode_i         = (r.kind == ROW_TICK) ? MODE_TICK : MODE_STORE;
      leg_i          = r.leg;
      alpha_i        = r.alpha;
      beta_i         = r.beta;
      gamma_i        = r.gamma;
      tick_time_us_i = r.dt;
      @(posedge clk);
      while (in_stall_o) @(posedge clk);
      if (r.kind == ROW_STORE) begin
        if (int'(r.leg) < NUM_LEGS) begin
          target_q[r.leg * JOINTS]     = r.alpha;
          target_q[r.leg * JOINTS + 1] = r.beta;
          target_q[r.leg * JOINTS + 2] = flip_angle(r.gamma);
        end
      end else begin
        advance_joints(r.dt);
        if (r.typed) begin
          tick_results[r.typed_slot].width = r.typed_width;
          tick_results[r.typed_slot].angle = r.typed_angle;
        end
        for (i = 0; i < SLOT_COUNT; i++) pending_joints.push_back(tick_results[i]);
      end
      @(negedge clk);
    end
  endtask

  // Receiver side: random stall runs plus one long hold-off on request.
  initial begin : recv_idle
    int left;
    bit stalling;
    left = 0;
    stalling = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        stalling = ($urandom_range(0, 9) < 4);
        if (stalling) begin
          left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        end else begin
          left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 6);
        end
      end
      left--;
      out_stall_i = hold_long || (stalling && !calm);
    end
  end

  initial begin : recv_hold
    hold_long = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_long = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_out
    joint_result_t want;
    joint_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.leg   = out_leg_o;
      got.joint = joint_o;
      got.width = width_ticks_o;
      got.angle = applied_angle_o;
      got.last  = last_o;
      if (pending_joints.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("unexpected joint result: leg %0d joint %0d width %0d angle %0d last %0d",
                   got.leg, got.joint, got.width, got.angle, got.last);
        end
      end else begin
        want = pending_joints.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("joint mismatch: expected leg %0d joint %0d width %0d angle %0d last %0d",
                     want.leg, want.joint, want.width, want.angle, want.last);
            $display("                actual   leg %0d joint %0d width %0d angle %0d last %0d",
                     got.leg, got.joint, got.width, got.angle, got.last);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    int i;
    int phase;
    int n;
    int j;
    int rate;
    int trim;
    stim_row_t r;
    logic [CFG_IDX_W-1:0] trim_index;

    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_STORE;
    leg_i          = '0;
    alpha_i        = '0;
    beta_i         = '0;
    gamma_i        = '0;
    tick_time_us_i = '0;
    errors         = 0;
    hold_req       = 1'b0;
    calm           = 1'b0;
    rate_q         = RATE_W'(RATE_AT_RESET);
    for (i = 0; i < SLOT_COUNT; i++) begin
      target_q[i]  = '0;
      current_q[i] = '0;
    end
    for (i = 0; i < JOINTS; i++) trim_q[i] = '0;

    // Directed table; slot numbers are leg * 3 + joint.
    dir_rows.push_back(with_check(item_row(ROW_TICK, 0, 0, 0, 0, 1000), 0, 307, 0));
    dir_rows.push_back(item_row(ROW_STORE, 0, 11520, -11520, 11520, 0));
    // The tibia target of this leg overflows on negation.
    dir_rows.push_back(item_row(ROW_STORE, 5, -16384, 16383, -16384, 65535));
    dir_rows.push_back(item_row(ROW_STORE, 6, 5000, 5000, 5000, 0));
    dir_rows.push_back(item_row(ROW_STORE, 7, -5000, -5000, -5000, 0));
    dir_rows.push_back(cfg_row(CFG_RATE, 1023));
    // Ticks ignore leg and angle fields.
    dir_rows.push_back(item_row(ROW_TICK, 7, 16383, -16384, 12345, 65535));
    dir_rows.push_back(item_row(ROW_TICK, 0, 0, 0, 0, 65535));
    dir_rows.push_back(with_check(item_row(ROW_TICK, 0, 0, 0, 0, 65535), 0, 490, 11520));
    dir_rows.push_back(with_check(item_row(ROW_TICK, 0, 0, 0, 0, 65535), 1, 99, -11520));
    dir_rows.push_back(with_check(item_row(ROW_TICK, 0, 0, 0, 0, 65535), 15, 490, -16384));
    dir_rows.push_back(cfg_row(CFG_RATE, 0));
    dir_rows.push_back(item_row(ROW_STORE, 1, 1000, -1000, 1000, 0));
    dir_rows.push_back(item_row(ROW_TICK, 0, 0, 0, 0, 65535));
    dir_rows.push_back(cfg_row(CFG_RATE, 1));
    dir_rows.push_back(item_row(ROW_TICK, 0, 0, 0, 0, 15624));
    dir_rows.push_back(item_row(ROW_TICK, 0, 0, 0, 0, 15625));
    dir_rows.push_back(cfg_row(CFG_COXA_TRIM, 2880));
    dir_rows.push_back(cfg_row(CFG_FEMUR_TRIM, -2880));
    dir_rows.push_back(cfg_row(CFG_TIBIA_TRIM, 4095));
    dir_rows.push_back(item_row(ROW_TICK, 0, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(CFG_TIBIA_TRIM, -4096));
    dir_rows.push_back(item_row(ROW_STORE, 3, 16383, -16384, 16383, 65535));
    dir_rows.push_back(cfg_row(CFG_RATE, 1023));
    dir_rows.push_back(item_row(ROW_TICK, 0, 0, 0, 0, 65535));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    for (i = 0; i < dir_rows.size(); i++) begin
      apply_row(dir_rows[i]);
      idle_gap();
    end

    for (phase = 0; phase < 5; phase++) begin
      calm = (phase == 4);
      if (phase == 1) begin
        rate = 1023;
      end else if (phase == 3) begin
        rate = 0;
      end else begin
        rate = $urandom_range(0, 1023);
      end
      apply_row(cfg_row(CFG_RATE, rate));
      for (j = 0; j < JOINTS; j++) begin
        if (phase == 1) begin
          trim = 2880;
        end else if (phase == 3) begin
          trim = -2880;
        end else if ($urandom_range(0, 1) == 0) begin
          trim = $urandom_range(0, 8191);
        end else begin
          trim = int'($urandom_range(0, 5760)) - 2880;
        end
        trim_index = (j == 0) ? CFG_COXA_TRIM : (j == 1) ? CFG_FEMUR_TRIM : CFG_TIBIA_TRIM;
        apply_row(cfg_row(trim_index, trim));
      end
      for (n = 0; n < 20; n++) begin
        r = random_request();
        // The receiver holds off through a whole tick while requests keep coming.
        if (phase == 0 && n == 0) begin
          r.kind = ROW_TICK;
          hold_req = 1'b1;
        end
        if (phase == 2 && n == 10) wait_idle();
        apply_row(r);
        idle_gap();
      end
    end

    in_valid_i = 1'b0;
    while (pending_joints.size() != 0) @(negedge clk);
    repeat (END_DRAIN) @(negedge clk);
    if (pending_joints.size() != 0) errors += pending_joints.size();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ servo_joint_slew_to_pulse_core.f @@
design/svjp_pkg.sv
design/servo_joint_slew_to_pulse_core.sv
design/svjp_checker.sv
test/testbench.sv
